@@ sv/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the pressure sensor compensation unit.
// ----------------------------------------------------------------------------
package psc_pkg;

  // width of the divider datapath
  localparam int DIV_W = 32;
  // divider stages, one quotient bit each
  localparam int DIV_STAGES = DIV_W;

  // configuration register indexes
  localparam logic [2:0] REG_CALIB0 = 3'd0;
  localparam logic [2:0] REG_CALIB1 = 3'd1;
  localparam logic [2:0] REG_CALIB2 = 3'd2;
  localparam logic [2:0] REG_CALIB3 = 3'd3;
  localparam logic [2:0] REG_OSS    = 3'd4;

  // compensation constants
  localparam logic signed [31:0] K_B6_OFS = 32'sd4000;
  localparam logic signed [31:0] K_B4_OFS = 32'sd32768;
  localparam logic [15:0]        K_B7_MUL = 16'd50000;
  localparam logic signed [31:0] K_P_X1   = 32'sd3038;
  localparam logic signed [31:0] K_P_X2   = -32'sd7357;
  localparam logic signed [31:0] K_P_OFS  = 32'sd3791;
  localparam logic signed [31:0] T_MAX    = 32'sd32767;
  localparam logic signed [31:0] T_MIN    = -32'sd32768;
  localparam logic signed [31:0] P_MAX    = 32'sd262143;

  // side data that rides along with a word through a divider
  typedef struct packed {
    logic [31:0] x1;    // temperature X1
    logic [18:0] up;    // raw pressure
    logic [15:0] t;     // compensated temperature
    logic        neg;   // quotient must be negated
    logic        zer;   // divisor was zero
    logic        post;  // quotient gets a final left shift
    logic        flt;   // fault so far
  } psc_tag_t;

endpackage

@@ sv/psc_div.sv @@
// ----------------------------------------------------------------------------
// psc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        dividend,
  input  logic [31:0]        divisor,
  input  psc_pkg::psc_tag_t  in_tag,
  output logic               out_valid,
  output logic [31:0]        quotient,
  output psc_pkg::psc_tag_t  out_tag
);
  import psc_pkg::*;

  logic [DIV_W-1:0] rem_r [1:DIV_STAGES];
  logic [DIV_W-1:0] dq_r  [1:DIV_STAGES];
  logic [DIV_W-1:0] dv_r  [1:DIV_STAGES];
  psc_tag_t         tag_r [1:DIV_STAGES];
  logic             vld_r [1:DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_W-1:0] rem_s, dq_s, dv_s;
    psc_tag_t         tag_s;
    logic             v_s;
    logic [DIV_W:0]   sh;
    logic             ge;

    // stage source: ports for the first stage, registers after that
    if (k == 0) begin : g_src_in
      assign rem_s = '0;
      assign dq_s  = dividend;
      assign dv_s  = divisor;
      assign tag_s = in_tag;
      assign v_s   = in_valid;
    end else begin : g_src_reg
      assign rem_s = rem_r[k];
      assign dq_s  = dq_r[k];
      assign dv_s  = dv_r[k];
      assign tag_s = tag_r[k];
      assign v_s   = vld_r[k];
    end

    // bring in the next dividend bit and try a subtract
    assign sh = {rem_s, dq_s[DIV_W-1]};
    assign ge = (sh >= {1'b0, dv_s});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? DIV_W'(sh - {1'b0, dv_s}) : sh[DIV_W-1:0];
        dq_r[k+1]  <= {dq_s[DIV_W-2:0], ge};
        dv_r[k+1]  <= dv_s;
        tag_r[k+1] <= tag_s;
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES];
  assign quotient  = dq_r[DIV_STAGES];
  assign out_tag   = tag_r[DIV_STAGES];

endmodule

@@ sv/pressure_sensor_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_unit
// Temperature and pressure compensation of a barometric sensor, integer method.
// ----------------------------------------------------------------------------
// Stages A-C, divider, D-H, divider, I, J, output (two 32-stage dividers).
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits, so in_tready follows out_tready when a result is pending.
// Reset: synchronous active-low rst_n clears all valid bits and the
// calibration registers; no clearing pass is needed.
module pressure_sensor_compensation_unit (
  input  logic        clk,
  input  logic        rst_n,
  // raw_temperature [15:0], raw_pressure [34:16], zero fill
  input  logic [39:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // temperature_tenths [15:0], pressure_pascal [33:16], fault [34], zero fill
  output logic [39:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import psc_pkg::*;

  // configuration registers
  logic [47:0] cw0_r, cw1_r, cw2_r;
  logic [31:0] cw3_r;
  logic [1:0]  oss_r;
  logic [2:0]  cidx;

  assign cfg_pready = 1'b1;
  assign cidx       = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw0_r <= '0;
      cw1_r <= '0;
      cw2_r <= '0;
      cw3_r <= '0;
      oss_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cidx)
        REG_CALIB0: cw0_r <= cfg_pwdata[47:0];
        REG_CALIB1: cw1_r <= cfg_pwdata[47:0];
        REG_CALIB2: cw2_r <= cfg_pwdata[47:0];
        REG_CALIB3: cw3_r <= cfg_pwdata[31:0];
        REG_OSS:    oss_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cidx)
      REG_CALIB0: cfg_prdata = {16'd0, cw0_r};
      REG_CALIB1: cfg_prdata = {16'd0, cw1_r};
      REG_CALIB2: cfg_prdata = {16'd0, cw2_r};
      REG_CALIB3: cfg_prdata = {32'd0, cw3_r};
      REG_OSS:    cfg_prdata = {62'd0, oss_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // coefficient fields
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = cw0_r[47:32];
  assign ac2 = cw0_r[31:16];
  assign ac3 = cw0_r[15:0];
  assign ac4 = cw1_r[47:32];
  assign ac5 = cw1_r[31:16];
  assign ac6 = cw1_r[15:0];
  assign b1  = cw2_r[47:32];
  assign b2  = cw2_r[31:16];
  assign mc  = cw3_r[31:16];
  assign md  = cw3_r[15:0];

  // global pipeline advance
  logic en;
  logic out_v_r;
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // ---- stage A: input register
  logic        a_v_r;
  logic [15:0] a_ut_r;
  logic [18:0] a_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_ut_r <= in_tdata[15:0];
      a_up_r <= in_tdata[34:16];
    end
  end

  // ---- stage B: X1 = ((UT - AC6) * AC5) >> 15
  logic               b_v_r;
  logic signed [31:0] b_x1_r;
  logic [18:0]        b_up_r;
  logic signed [16:0] b_d;
  logic signed [33:0] b_m;
  logic signed [31:0] b_m32;
  assign b_d   = $signed({1'b0, a_ut_r}) - $signed({1'b0, ac6});
  assign b_m   = b_d * $signed({1'b0, ac5});
  assign b_m32 = b_m[31:0];
  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= a_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_x1_r <= b_m32 >>> 15;
      b_up_r <= a_up_r;
    end
  end

  // ---- stage C: operands of MC*2048 / (X1+MD) as magnitudes
  logic               c_v_r;
  logic [31:0]        c_nmag_r, c_dmag_r;
  psc_tag_t           c_tag_r;
  logic signed [31:0] c_x3, c_num;
  assign c_x3  = b_x1_r + 32'(md);
  assign c_num = 32'(mc) <<< 11;
  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= b_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_nmag_r <= c_num[31] ? 32'(-c_num) : c_num;
      c_dmag_r <= c_x3[31] ? 32'(-c_x3) : c_x3;
      c_tag_r  <= '{x1: b_x1_r, up: b_up_r, t: 16'd0,
                    neg: c_num[31] ^ c_x3[31], zer: (c_x3 == 32'sd0),
                    post: 1'b0, flt: (c_x3 == 32'sd0)};
    end
  end

  // temperature divider
  logic        dt_v;
  logic [31:0] dt_q;
  psc_tag_t    dt_tag;
  psc_div u_div_t (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(c_v_r), .dividend(c_nmag_r), .divisor(c_dmag_r), .in_tag(c_tag_r),
    .out_valid(dt_v), .quotient(dt_q), .out_tag(dt_tag)
  );

  // ---- stage D: B5, temperature, B6
  logic               d_v_r, d_flt_r;
  logic [15:0]        d_t_r;
  logic signed [31:0] d_b6_r;
  logic [18:0]        d_up_r;
  logic signed [31:0] d_x2, d_b5, d_tf;
  logic [15:0]        d_t;
  always_comb begin
    if (dt_tag.zer)      d_x2 = '0;
    else if (dt_tag.neg) d_x2 = 32'(-dt_q);
    else                 d_x2 = dt_q;
    d_b5 = $signed(dt_tag.x1) + d_x2;
    d_tf = (d_b5 + 32'sd8) >>> 4;
    if (d_tf > T_MAX)      d_t = T_MAX[15:0];
    else if (d_tf < T_MIN) d_t = T_MIN[15:0];
    else                   d_t = d_tf[15:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (en) d_v_r <= dt_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_t_r   <= d_t;
      d_b6_r  <= d_b5 - K_B6_OFS;
      d_up_r  <= dt_tag.up;
      d_flt_r <= dt_tag.flt;
    end
  end

  // ---- stage E: B6*B6, AC2*B6, AC3*B6
  logic               e_v_r, e_flt_r;
  logic [15:0]        e_t_r;
  logic [18:0]        e_up_r;
  logic signed [31:0] e_sq_r, e_a2_r, e_a3_r;
  logic signed [63:0] e_m0;
  logic signed [47:0] e_m2, e_m3;
  assign e_m0 = d_b6_r * d_b6_r;
  assign e_m2 = ac2 * d_b6_r;
  assign e_m3 = ac3 * d_b6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (en) e_v_r <= d_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_sq_r  <= e_m0[31:0];
      e_a2_r  <= e_m2[31:0];
      e_a3_r  <= e_m3[31:0];
      e_t_r   <= d_t_r;
      e_up_r  <= d_up_r;
      e_flt_r <= d_flt_r;
    end
  end

  // ---- stage F: B2*sq, B1*sq, AC2*B6 >> 11, AC3*B6 >> 13
  logic               f_v_r, f_flt_r;
  logic [15:0]        f_t_r;
  logic [18:0]        f_up_r;
  logic signed [31:0] f_b2sq_r, f_b1sq_r, f_x2a_r, f_x1c_r;
  logic signed [31:0] f_sq;
  logic signed [47:0] f_m2, f_m1;
  assign f_sq = e_sq_r >>> 12;
  assign f_m2 = b2 * f_sq;
  assign f_m1 = b1 * f_sq;
  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (en) f_v_r <= e_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_b2sq_r <= f_m2[31:0];
      f_b1sq_r <= f_m1[31:0];
      f_x2a_r  <= e_a2_r >>> 11;
      f_x1c_r  <= e_a3_r >>> 13;
      f_t_r    <= e_t_r;
      f_up_r   <= e_up_r;
      f_flt_r  <= e_flt_r;
    end
  end

  // ---- stage G: B3 and the X3 term of B4
  logic               g_v_r, g_flt_r;
  logic [15:0]        g_t_r;
  logic [18:0]        g_up_r;
  logic signed [31:0] g_b3_r, g_x3_r;
  logic signed [31:0] g_x3a, g_s, g_sh;
  assign g_x3a = (f_b2sq_r >>> 11) + f_x2a_r;
  assign g_s   = (32'(ac1) <<< 2) + g_x3a;
  assign g_sh  = g_s << oss_r;
  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else if (en) g_v_r <= f_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_b3_r  <= (g_sh + 32'sd2) >>> 2;
      g_x3_r  <= (f_x1c_r + (f_b1sq_r >>> 16) + 32'sd2) >>> 2;
      g_t_r   <= f_t_r;
      g_up_r  <= f_up_r;
      g_flt_r <= f_flt_r;
    end
  end

  // ---- stage H: B4 and B7, unsigned
  logic        h_v_r, h_flt_r;
  logic [15:0] h_t_r;
  logic [31:0] h_b4_r, h_b7_r;
  logic [31:0] h_s4, h_dp;
  logic [47:0] h_m4, h_m7;
  assign h_s4 = g_x3_r + K_B4_OFS;
  assign h_m4 = ac4 * h_s4;
  assign h_dp = {13'd0, g_up_r} - g_b3_r;
  assign h_m7 = h_dp * (K_B7_MUL >> oss_r);
  always_ff @(posedge clk) begin
    if (!rst_n) h_v_r <= 1'b0;
    else if (en) h_v_r <= g_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h_b4_r  <= h_m4[31:0] >> 15;
      h_b7_r  <= h_m7[31:0];
      h_t_r   <= g_t_r;
      h_flt_r <= g_flt_r;
    end
  end

  // pressure divider operands
  psc_tag_t    dp_itag;
  logic [31:0] dp_dvd;
  always_comb begin
    dp_itag      = '0;
    dp_itag.t    = h_t_r;
    dp_itag.post = h_b7_r[31];
    dp_itag.zer  = (h_b4_r == 32'd0);
    dp_itag.flt  = h_flt_r || (h_b4_r == 32'd0);
    dp_dvd       = h_b7_r[31] ? h_b7_r : {h_b7_r[30:0], 1'b0};
  end

  logic        dp_v;
  logic [31:0] dp_q;
  psc_tag_t    dp_tag;
  psc_div u_div_p (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(h_v_r), .dividend(dp_dvd), .divisor(h_b4_r), .in_tag(dp_itag),
    .out_valid(dp_v), .quotient(dp_q), .out_tag(dp_tag)
  );

  // ---- stage I: (p>>8)^2 and -7357*p
  logic               i_v_r, i_zer_r, i_flt_r;
  logic [15:0]        i_t_r;
  logic signed [31:0] i_p_r, i_x1_r, i_x2_r;
  logic signed [31:0] i_p, i_ps;
  logic signed [63:0] i_m1, i_m2;
  assign i_p  = dp_tag.post ? {dp_q[30:0], 1'b0} : dp_q;
  assign i_ps = i_p >>> 8;
  assign i_m1 = i_ps * i_ps;
  assign i_m2 = K_P_X2 * i_p;
  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (en) i_v_r <= dp_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      i_p_r   <= i_p;
      i_x1_r  <= i_m1[31:0];
      i_x2_r  <= i_m2[31:0];
      i_t_r   <= dp_tag.t;
      i_zer_r <= dp_tag.zer;
      i_flt_r <= dp_tag.flt;
    end
  end

  // ---- stage J: X1 * 3038
  logic               j_v_r, j_zer_r, j_flt_r;
  logic [15:0]        j_t_r;
  logic signed [31:0] j_p_r, j_m_r, j_x2_r;
  logic signed [63:0] j_m;
  assign j_m = i_x1_r * K_P_X1;
  always_ff @(posedge clk) begin
    if (!rst_n) j_v_r <= 1'b0;
    else if (en) j_v_r <= i_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      j_m_r   <= j_m[31:0];
      j_x2_r  <= i_x2_r >>> 16;
      j_p_r   <= i_p_r;
      j_t_r   <= i_t_r;
      j_zer_r <= i_zer_r;
      j_flt_r <= i_flt_r;
    end
  end

  // ---- output stage: final sum and saturation
  logic               out_flt_r;
  logic [15:0]        out_t_r;
  logic [17:0]        out_p_r;
  logic signed [31:0] k_pp;
  logic [17:0]        k_p;
  always_comb begin
    k_pp = j_p_r + (((j_m_r >>> 16) + j_x2_r + K_P_OFS) >>> 4);
    if (j_zer_r || k_pp < 32'sd0) k_p = '0;
    else if (k_pp > P_MAX)        k_p = P_MAX[17:0];
    else                          k_p = k_pp[17:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= j_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_t_r   <= j_t_r;
      out_p_r   <= k_p;
      out_flt_r <= j_flt_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_flt_r, out_p_r, out_t_r};

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready) else $error("input blocked with no pending word");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output word valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("pending output word changed");

endmodule
